### rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// assertion macros used by the checker file
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define KBL_ASSERT_IMPLY(label, clk, rst_n, cond, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (expr)) \
        else $error(msg);

// next-cycle implication
`define KBL_ASSERT_NEXT(label, clk, rst_n, cond, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expr)) \
        else $error(msg);

`endif

### rtl/kbl_pkg.sv
// ----------------------------------------------------------------------------
// kbl_pkg
// shared types and constants of the key-toggled breathing light
// ----------------------------------------------------------------------------
`default_nettype none

package kbl_pkg;

    localparam logic [7:0]  LONG_PRESS_RESET = 8'd50;

    localparam logic [11:0] RAMP_PERIOD      = 12'd1800;
    localparam logic [10:0] RISE_STEPS       = 11'd1100;
    localparam logic [8:0]  PEAK_LEVEL       = 9'd500;

    // level = floor(5c/11) on the rise, 500 - floor(5d/7) on the fall
    localparam int          RECIP_SHIFT      = 16;
    localparam logic [13:0] RISE_RECIP       = 14'd5958;
    localparam logic [13:0] FALL_RECIP       = 14'd9363;

    localparam logic        REQ_KEY          = 1'b0;
    localparam logic        REQ_BREATH       = 1'b1;

    typedef struct packed {
        logic running;
        logic report;
        logic led_off;
    } key_result_t;

endpackage

`default_nettype wire

### rtl/kbl_key.sv
// ----------------------------------------------------------------------------
// kbl_key
// press state machine: short press report, long press run toggle
// ----------------------------------------------------------------------------
`default_nettype none

module kbl_key (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               step,
    input  wire logic               key_level,
    input  wire logic [7:0]         threshold,
    output kbl_pkg::key_result_t    result,
    output logic                    run_flag
);
    import kbl_pkg::*;

    typedef enum logic [2:0] {
        KEY_RELEASED = 3'b001,
        KEY_COUNTING = 3'b010,
        KEY_WAIT     = 3'b100
    } key_phase_t;

    key_phase_t phase_reg, phase_next;
    logic [7:0] count_reg, count_next;
    logic       run_reg,   run_next;
    logic       report;
    logic       led_off;

    always_comb
    begin
        phase_next = phase_reg;
        count_next = count_reg;
        run_next   = run_reg;
        report     = 1'b0;
        led_off    = 1'b0;
        if (step)
        begin
            case (phase_reg)
                KEY_COUNTING:
                begin
                    if (count_reg >= threshold)
                    begin
                        if (key_level)
                        begin
                            run_next   = ~run_reg;
                            led_off    = run_reg;
                            count_next = 8'd0;
                        end
                        phase_next = KEY_WAIT;
                    end
                    else if (!key_level)
                    begin
                        report     = 1'b1;
                        count_next = 8'd0;
                        phase_next = KEY_RELEASED;
                    end
                    else
                    begin
                        count_next = count_reg + 8'd1;
                    end
                end
                KEY_WAIT:
                begin
                    if (!key_level)
                    begin
                        phase_next = KEY_RELEASED;
                        count_next = 8'd0;
                    end
                end
                default:
                begin
                    count_next = {7'd0, key_level};
                    phase_next = key_level ? KEY_COUNTING : KEY_RELEASED;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= KEY_RELEASED;
            count_reg <= 8'd0;
            run_reg   <= 1'b0;
        end
        else
        begin
            phase_reg <= phase_next;
            count_reg <= count_next;
            run_reg   <= run_next;
        end
    end

    assign result.running = run_next;
    assign result.report  = report;
    assign result.led_off = led_off;
    assign run_flag       = run_reg;

endmodule

`default_nettype wire

### rtl/kbl_ramp.sv
// ----------------------------------------------------------------------------
// kbl_ramp
// breathing ramp counter and pwm compare level
// ----------------------------------------------------------------------------
`default_nettype none

module kbl_ramp (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       step,
    input  wire logic       run_flag,
    output logic [8:0]      level_next
);
    import kbl_pkg::*;

    logic [10:0] ramp_reg,  ramp_next;
    logic [8:0]  level_reg;
    logic [11:0] count_inc;
    logic [10:0] wrapped;
    logic        rising;
    logic [10:0] offset;
    logic [12:0] scaled;
    logic [13:0] recip;
    logic [26:0] product;
    logic [8:0]  quot;
    logic [8:0]  ramp_level;

    always_comb
    begin
        count_inc  = {1'b0, ramp_reg} + 12'd1;
        wrapped    = (count_inc >= RAMP_PERIOD) ? 11'd0 : count_inc[10:0];
        rising     = (wrapped <= RISE_STEPS);
        offset     = rising ? wrapped : (wrapped - RISE_STEPS);
        scaled     = ({2'b00, offset} << 2) + {2'b00, offset};
        recip      = rising ? RISE_RECIP : FALL_RECIP;
        product    = 27'(scaled) * 27'(recip);
        quot       = product[RECIP_SHIFT +: 9];
        ramp_level = rising ? quot : (PEAK_LEVEL - quot);
    end

    always_comb
    begin
        ramp_next  = ramp_reg;
        level_next = level_reg;
        if (step)
        begin
            if (run_flag)
            begin
                ramp_next  = wrapped;
                level_next = ramp_level;
            end
            else
            begin
                level_next = 9'd0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ramp_reg  <= 11'd0;
            level_reg <= 9'd0;
        end
        else
        begin
            ramp_reg  <= ramp_next;
            level_reg <= level_next;
        end
    end

endmodule

`default_nettype wire

### rtl/key_toggled_breathing_light.sv
// ----------------------------------------------------------------------------
// key_toggled_breathing_light
// button press handling with a breathing pwm compare value
//
//   channel   direction   handshake            payload
//   in        input       in_valid / in_stall   req_type, key_level
//   out       output      out_valid / out_stall pwm_compare, running,
//                                              report_request, led_off_request
//   cfg       input       cfg_we               cfg_wdata (long press samples)
//
// one transfer per cycle sustained while out_stall is low; each item
// passes through the input register, then the result register
// the key machine and ramp counter update when the item moves into the
// result register, so back-to-back items see each other's state
// reset clears valid, key and ramp state; long press threshold back to 50
// in_stall rises only when both registers hold data and out_stall is high
// ----------------------------------------------------------------------------
`default_nettype none

module key_toggled_breathing_light (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_stall,
    input  wire logic       req_type,
    input  wire logic       key_level,
    output logic            out_valid,
    input  wire logic       out_stall,
    output logic [8:0]      pwm_compare,
    output logic            running,
    output logic            report_request,
    output logic            led_off_request,
    input  wire logic       cfg_we,
    input  wire logic [7:0] cfg_wdata
);
    import kbl_pkg::*;

    logic        in_valid_reg,  in_valid_next;
    logic        req_type_reg;
    logic        key_level_reg;
    logic        out_valid_reg, out_valid_next;
    logic [8:0]  pwm_reg;
    logic        running_reg;
    logic        report_reg;
    logic        led_off_reg;
    logic [7:0]  threshold_reg;

    logic        advance;
    logic        in_load;
    logic        step;
    logic        key_step;
    logic        ramp_step;
    logic        run_flag;
    logic [8:0]  level_next;
    key_result_t key_res;

    assign advance   = !out_valid_reg || !out_stall;
    assign in_stall  = in_valid_reg && !advance;
    assign in_load   = in_valid && !in_stall;
    assign step      = in_valid_reg && advance;
    assign key_step  = step && (req_type_reg == REQ_KEY);
    assign ramp_step = step && (req_type_reg == REQ_BREATH);

    assign in_valid_next  = in_load ? 1'b1 : (advance ? 1'b0 : in_valid_reg);
    assign out_valid_next = step ? 1'b1 : (advance ? 1'b0 : out_valid_reg);

    kbl_key u_key (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (key_step),
        .key_level (key_level_reg),
        .threshold (threshold_reg),
        .result    (key_res),
        .run_flag  (run_flag)
    );

    kbl_ramp u_ramp (
        .clk        (clk),
        .rst_n      (rst_n),
        .step       (ramp_step),
        .run_flag   (run_flag),
        .level_next (level_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            threshold_reg <= LONG_PRESS_RESET;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
            begin
                threshold_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_load)
        begin
            req_type_reg  <= req_type;
            key_level_reg <= key_level;
        end
        if (step)
        begin
            pwm_reg     <= level_next;
            running_reg <= key_res.running;
            report_reg  <= key_res.report;
            led_off_reg <= key_res.led_off;
        end
    end

    assign out_valid       = out_valid_reg;
    assign pwm_compare     = pwm_reg;
    assign running         = running_reg;
    assign report_request  = report_reg;
    assign led_off_request = led_off_reg;

endmodule

`default_nettype wire

### rtl/kbl_checker.sv
// ----------------------------------------------------------------------------
// kbl_checker
// port-level checks of the key-toggled breathing light
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module kbl_checker (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       out_valid,
    input  wire logic       out_stall,
    input  wire logic [8:0] pwm_compare,
    input  wire logic       running,
    input  wire logic       report_request,
    input  wire logic       led_off_request
);

    `KBL_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(pwm_compare) && $stable(running), "stalled result changed")
    `KBL_ASSERT_IMPLY(a_pwm_range, clk, rst_n, out_valid, pwm_compare <= 9'd500, "pwm compare above peak")
    `KBL_ASSERT_IMPLY(a_pulse_excl, clk, rst_n, out_valid, !(report_request && led_off_request), "report and led off in one transfer")
    `KBL_ASSERT_IMPLY(a_led_off_stop, clk, rst_n, out_valid && led_off_request, !running, "led off request while running")

endmodule

bind key_toggled_breathing_light kbl_checker u_kbl_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .pwm_compare     (pwm_compare),
    .running         (running),
    .report_request  (report_request),
    .led_off_request (led_off_request)
);

`default_nettype wire

### verif/key_toggled_breathing_light_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// key_toggled_breathing_light_tb
// self-checking testbench for the key-toggled breathing light
//
// drives key and breathing ticks over the valid/stall input channel and keeps
// its own model of the press machine, run flag and pwm ramp. every result
// transfer is compared field by field against the oldest predicted result.
// directed tests cover short press, release at the threshold, long press on
// and off, and a zero threshold. a long ramp sweep then climbs most of the
// rising slope. random press sequences and noise follow, in phases with
// different thresholds, input gaps and output stalls.
// ----------------------------------------------------------------------------

module key_toggled_breathing_light_tb;

    import kbl_pkg::*;

    localparam int FALL_STEPS = 700;

    typedef enum logic [1:0] {
        KEY_RELEASED,
        KEY_COUNTING,
        KEY_WAIT_RELEASE
    } key_phase_t;

    typedef struct {
        logic [8:0] pwm;
        logic       running;
        logic       report;
        logic       led_off;
    } light_result_t;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       in_valid = 1'b0;
    logic       in_stall;
    logic       req_type = 1'b0;
    logic       key_level = 1'b0;
    logic       out_valid;
    logic       out_stall = 1'b0;
    logic [8:0] pwm_compare;
    logic       running;
    logic       report_request;
    logic       led_off_request;
    logic       cfg_we = 1'b0;
    logic [7:0] cfg_wdata = 8'd0;

    key_phase_t    phase;
    logic [7:0]    press_cnt;
    logic [7:0]    threshold;
    logic          run_on;
    int unsigned   ramp_pos;
    logic [8:0]    level;
    light_result_t pending_lights[$];
    light_result_t seen;

    int error_count = 0;
    int items_sent = 0;
    int send_idle_pct = 0;
    int stall_pct = 0;

    key_toggled_breathing_light dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .req_type        (req_type),
        .key_level       (key_level),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .pwm_compare     (pwm_compare),
        .running         (running),
        .report_request  (report_request),
        .led_off_request (led_off_request),
        .cfg_we          (cfg_we),
        .cfg_wdata       (cfg_wdata)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    function automatic logic [8:0] breath_level(input int unsigned c);
        if (c <= RISE_STEPS)
            return 9'((c * PEAK_LEVEL) / RISE_STEPS);
        return 9'(PEAK_LEVEL - ((c - RISE_STEPS) * PEAK_LEVEL) / FALL_STEPS);
    endfunction

    task automatic predict_light(input logic rt, input logic kl);
        light_result_t r;
        r.report = 1'b0;
        r.led_off = 1'b0;
        if (rt == REQ_KEY)
        begin
            case (phase)
                KEY_COUNTING:
                begin
                    if (press_cnt >= threshold)
                    begin
                        if (kl)
                        begin
                            run_on = !run_on;
                            if (!run_on)
                                r.led_off = 1'b1;
                            press_cnt = 8'd0;
                        end
                        phase = KEY_WAIT_RELEASE;
                    end
                    else if (!kl)
                    begin
                        r.report = 1'b1;
                        press_cnt = 8'd0;
                        phase = KEY_RELEASED;
                    end
                    else
                    begin
                        press_cnt = press_cnt + 8'd1;
                    end
                end
                KEY_WAIT_RELEASE:
                begin
                    if (!kl)
                    begin
                        phase = KEY_RELEASED;
                        press_cnt = 8'd0;
                    end
                end
                default:
                begin
                    press_cnt = kl ? 8'd1 : 8'd0;
                    phase = kl ? KEY_COUNTING : KEY_RELEASED;
                end
            endcase
        end
        else if (run_on)
        begin
            ramp_pos = (ramp_pos + 1 >= RAMP_PERIOD) ? 0 : ramp_pos + 1;
            level = breath_level(ramp_pos);
        end
        else
        begin
            level = 9'd0;
        end
        r.pwm = level;
        r.running = run_on;
        pending_lights.push_back(r);
    endtask

    task automatic send_tick(input logic rt, input logic kl);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid  <= 1'b1;
        req_type  <= rt;
        key_level <= kl;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        predict_light(rt, kl);
        items_sent++;
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        while (pending_lights.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic set_press_threshold(input logic [7:0] value);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we    <= 1'b0;
        threshold = value;
    endtask

    // press held for the given number of key samples, then released
    task automatic send_press(input int held, input int releases);
        for (int i = 0; i < held; i++)
        begin
            if ($urandom_range(0, 2) == 0)
                repeat ($urandom_range(1, 3)) send_tick(REQ_BREATH, 1'($urandom));
            send_tick(REQ_KEY, 1'b1);
        end
        repeat (releases) send_tick(REQ_KEY, 1'b0);
    endtask

    task automatic test_stopped_idle();
        send_tick(REQ_BREATH, 1'b0);
        send_tick(REQ_BREATH, 1'b1);
        send_tick(REQ_KEY, 1'b0);
    endtask

    task automatic test_short_press();
        send_press(1, 1);
    endtask

    task automatic test_release_at_threshold();
        send_press(int'(threshold), 2);
    endtask

    task automatic test_long_press_on();
        send_press(int'(threshold) + 2, 1);
        send_tick(REQ_BREATH, 1'b1);
        send_tick(REQ_BREATH, 1'b0);
        send_tick(REQ_BREATH, 1'b1);
    endtask

    task automatic test_long_press_off();
        send_press(int'(threshold) + 1, 1);
        send_tick(REQ_BREATH, 1'b0);
    endtask

    task automatic test_zero_threshold();
        wait_drained();
        set_press_threshold(8'd0);
        send_press(2, 1);
        send_press(2, 1);
    endtask

    task automatic test_full_ramp();
        wait_drained();
        set_press_threshold(8'd4);
        send_press(5, 1);
        repeat (660) send_tick(REQ_BREATH, 1'($urandom));
        send_press(5, 1);
        send_tick(REQ_BREATH, 1'b1);
    endtask

    task automatic test_random_traffic();
        int          send_pcts[4] = '{0, 50, 0, 30};
        int          stall_pcts[4] = '{0, 0, 50, 30};
        logic [7:0]  thr;
        int          phase_end;
        int          held;
        for (int p = 0; p < 4; p++)
        begin
            wait_drained();
            case (p)
                0: thr = 8'd1;
                1: thr = 8'($urandom_range(2, 20));
                2: thr = 8'd30;
                default: thr = 8'd0;
            endcase
            set_press_threshold(thr);
            send_idle_pct = send_pcts[p];
            stall_pct = stall_pcts[p];
            phase_end = items_sent + 100;
            while (items_sent < phase_end)
            begin
                if ($urandom_range(0, 99) < 15)
                begin
                    send_tick(1'($urandom), 1'($urandom));
                end
                else
                begin
                    case ($urandom_range(0, 3))
                        0: held = (thr == 0) ? 1 : $urandom_range(1, int'(thr));
                        1: held = int'(thr) + 1;
                        2: held = (thr == 0) ? 1 : int'(thr);
                        default: held = int'(thr) + 1 + $urandom_range(0, 5);
                    endcase
                    send_press(held, $urandom_range(1, 3));
                end
            end
        end
        send_idle_pct = 0;
        stall_pct = 0;
    endtask

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_lights.size() == 0)
            begin
                $display("%0t: unexpected result transfer, pwm_compare %0d", $time, pwm_compare);
                error_count++;
            end
            else
            begin
                seen = pending_lights.pop_front();
                if (pwm_compare !== seen.pwm)
                begin
                    $display("%0t: pwm_compare expected %0d actual %0d",
                             $time, seen.pwm, pwm_compare);
                    error_count++;
                end
                if (running !== seen.running)
                begin
                    $display("%0t: running expected %0b actual %0b",
                             $time, seen.running, running);
                    error_count++;
                end
                if (report_request !== seen.report)
                begin
                    $display("%0t: report_request expected %0b actual %0b",
                             $time, seen.report, report_request);
                    error_count++;
                end
                if (led_off_request !== seen.led_off)
                begin
                    $display("%0t: led_off_request expected %0b actual %0b",
                             $time, seen.led_off, led_off_request);
                    error_count++;
                end
            end
        end
        out_stall <= ($urandom_range(0, 99) < stall_pct);
    end

    initial
    begin
        phase = KEY_RELEASED;
        press_cnt = 8'd0;
        threshold = LONG_PRESS_RESET;
        run_on = 1'b0;
        ramp_pos = 0;
        level = 9'd0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_stopped_idle();
        wait_drained();
        set_press_threshold(8'd2);
        test_short_press();
        test_release_at_threshold();
        test_long_press_on();
        test_long_press_off();
        test_zero_threshold();
        test_full_ramp();
        test_random_traffic();
        wait_drained();
        repeat (8) @(posedge clk);
        if (error_count == 0)
            $display("key_toggled_breathing_light_tb: clean");
        else
            $display("key_toggled_breathing_light_tb: errors");
        $finish;
    end

    initial
    begin
        #2_000_000;
        $display("key_toggled_breathing_light_tb: errors");
        $finish;
    end

endmodule

### sim.f
+incdir+rtl
rtl/kbl_pkg.sv
rtl/kbl_key.sv
rtl/kbl_ramp.sv
rtl/key_toggled_breathing_light.sv
rtl/kbl_checker.sv
verif/key_toggled_breathing_light_tb.sv
